@@ rtl/flcpc_pkg.sv @@
// Shared types and constants for the four loop cascade position controller.
// Used by every module of the block; depends on nothing.
`default_nettype none

package flcpc_pkg;

    // fixed point format and widths
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 31;
    localparam int PROD_W    = DATA_W + GAIN_W;
    localparam int IDX_W     = 3;

    // register indexes on the configuration port
    typedef enum logic [IDX_W-1:0] {
        REG_POS_GAIN,
        REG_CART_VEL_GAIN,
        REG_ANGLE_GAIN,
        REG_SPEED_PROP_GAIN,
        REG_SPEED_INT_GAIN,
        REG_ANGLE_LIMIT,
        REG_INTEGRATOR_LIMIT
    } reg_idx_t;

    // reset values of the configuration registers
    localparam logic [GAIN_W-1:0] POS_GAIN_RST         = GAIN_W'(234057);
    localparam logic [GAIN_W-1:0] CART_VEL_GAIN_RST    = GAIN_W'(85893);
    localparam logic [GAIN_W-1:0] ANGLE_GAIN_RST       = GAIN_W'(524288);
    localparam logic [GAIN_W-1:0] SPEED_PROP_GAIN_RST  = GAIN_W'(125365);
    localparam logic [GAIN_W-1:0] SPEED_INT_GAIN_RST   = GAIN_W'(1319625);
    localparam logic [GAIN_W-1:0] ANGLE_LIMIT_RST      = GAIN_W'(22938);
    localparam logic [GAIN_W-1:0] INTEGRATOR_LIMIT_RST = GAIN_W'(196608);

    typedef struct packed {
        logic [GAIN_W-1:0] pos_gain;
        logic [GAIN_W-1:0] cart_vel_gain;
        logic [GAIN_W-1:0] angle_gain;
        logic [GAIN_W-1:0] speed_prop_gain;
        logic [GAIN_W-1:0] speed_int_gain;
        logic [GAIN_W-1:0] angle_limit;
        logic [GAIN_W-1:0] integrator_limit;
    } cfg_t;

    // which loop error the subtractor forms
    typedef enum logic [1:0] {
        DIFF_POS,
        DIFF_VEL,
        DIFF_ANG,
        DIFF_SPD
    } diff_sel_t;

    // which gain feeds the shared multiplier
    typedef enum logic [2:0] {
        GAIN_POS,
        GAIN_CVEL,
        GAIN_ANG,
        GAIN_KI,
        GAIN_KP
    } gain_sel_t;

    // command from the sequencer to the datapath
    typedef struct packed {
        logic      diff_en;
        diff_sel_t diff_sel;
        logic      mul_en;
        gain_sel_t gain_sel;
        logic      clamp_en;
        logic      integ_en;
        logic      out_en;
    } dp_cmd_t;

endpackage

`default_nettype wire

@@ rtl/flcpc_cfg_regs.sv @@
// Configuration register file of the cascade controller.
// Depends on flcpc_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module flcpc_cfg_regs
    import flcpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_index,
    input  wire logic [GAIN_W-1:0] wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the register index, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_POS_GAIN:         cfg_next.pos_gain         = wr_data;
                REG_CART_VEL_GAIN:    cfg_next.cart_vel_gain    = wr_data;
                REG_ANGLE_GAIN:       cfg_next.angle_gain       = wr_data;
                REG_SPEED_PROP_GAIN:  cfg_next.speed_prop_gain  = wr_data;
                REG_SPEED_INT_GAIN:   cfg_next.speed_int_gain   = wr_data;
                REG_ANGLE_LIMIT:      cfg_next.angle_limit      = wr_data;
                REG_INTEGRATOR_LIMIT: cfg_next.integrator_limit = wr_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_gain         <= POS_GAIN_RST;
            cfg_reg.cart_vel_gain    <= CART_VEL_GAIN_RST;
            cfg_reg.angle_gain       <= ANGLE_GAIN_RST;
            cfg_reg.speed_prop_gain  <= SPEED_PROP_GAIN_RST;
            cfg_reg.speed_int_gain   <= SPEED_INT_GAIN_RST;
            cfg_reg.angle_limit      <= ANGLE_LIMIT_RST;
            cfg_reg.integrator_limit <= INTEGRATOR_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/flcpc_datapath.sv @@
// Datapath of the cascade controller: input capture, error subtractor,
// shared gain multiplier, clamps, speed integrator and output register.
// Depends on flcpc_pkg; driven by commands from flcpc_ctrl.
`default_nettype none

module flcpc_datapath
    import flcpc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     load,
    input  wire dp_cmd_t                  cmd,
    input  wire cfg_t                     cfg,
    input  wire logic signed [DATA_W-1:0] target_raw,
    input  wire logic signed [DATA_W-1:0] cart_position_raw,
    input  wire logic signed [DATA_W-1:0] cart_velocity_raw,
    input  wire logic signed [DATA_W-1:0] motor_angle,
    input  wire logic signed [DATA_W-1:0] motor_speed,
    output logic signed [DATA_W-1:0]      drive_voltage
);

    localparam int SH_W = PROD_W - FRAC_BITS;
    localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // saturate a value one bit wider than the data width
    function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1])
            r = v[DATA_W] ? S_MIN : S_MAX;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // saturating negation
    function automatic logic signed [DATA_W-1:0] neg_sat(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v == S_MIN)
            r = S_MAX;
        else
            r = -v;
        return r;
    endfunction

    // symmetric clamp to plus or minus an unsigned limit
    function automatic logic signed [DATA_W-1:0] clamp_sym(input logic signed [DATA_W:0] v,
                                                           input logic [GAIN_W-1:0] lim);
        logic signed [DATA_W:0]   l;
        logic signed [DATA_W:0]   nl;
        logic signed [DATA_W-1:0] r;
        l  = {2'b00, lim};
        nl = -l;
        if (v > l)
            r = l[DATA_W-1:0];
        else if (v < nl)
            r = nl[DATA_W-1:0];
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    logic signed [DATA_W-1:0] setp_reg;
    logic signed [DATA_W-1:0] pos_reg;
    logic signed [DATA_W-1:0] cvel_reg;
    logic signed [DATA_W-1:0] theta_reg;
    logic signed [DATA_W-1:0] mspeed_reg;
    logic signed [DATA_W-1:0] err_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DATA_W-1:0] ang_reg;
    logic signed [DATA_W-1:0] integ_reg;
    logic signed [DATA_W-1:0] integ_next;
    logic signed [DATA_W-1:0] drive_reg;

    logic signed [SH_W-1:0]     shifted;
    logic                       hi_ok;
    logic signed [DATA_W-1:0]   scaled;
    logic signed [DATA_W-1:0]   lhs;
    logic signed [DATA_W-1:0]   rhs;
    logic signed [DATA_W:0]     diff_full;
    logic [GAIN_W-1:0]          gain;
    logic signed [2*DATA_W-1:0] mul_full;
    logic signed [DATA_W:0]     integ_sum;
    logic signed [DATA_W:0]     out_sum;

    // product scaled back to the fixed point format, floor then saturate
    assign shifted = prod_reg[PROD_W-1:FRAC_BITS];
    assign hi_ok   = (&shifted[SH_W-1:DATA_W-1]) | ~(|shifted[SH_W-1:DATA_W-1]);
    assign scaled  = hi_ok ? shifted[DATA_W-1:0] : (shifted[SH_W-1] ? S_MIN : S_MAX);

    // loop error operands
    always_comb
    begin
        case (cmd.diff_sel)
            DIFF_POS:
            begin
                lhs = setp_reg;
                rhs = pos_reg;
            end
            DIFF_VEL:
            begin
                lhs = scaled;
                rhs = cvel_reg;
            end
            DIFF_ANG:
            begin
                lhs = ang_reg;
                rhs = theta_reg;
            end
            DIFF_SPD:
            begin
                lhs = scaled;
                rhs = mspeed_reg;
            end
            default:
            begin
                lhs = setp_reg;
                rhs = pos_reg;
            end
        endcase
    end

    assign diff_full = {lhs[DATA_W-1], lhs} - {rhs[DATA_W-1], rhs};

    // gain select for the shared multiplier
    always_comb
    begin
        case (cmd.gain_sel)
            GAIN_POS:  gain = cfg.pos_gain;
            GAIN_CVEL: gain = cfg.cart_vel_gain;
            GAIN_ANG:  gain = cfg.angle_gain;
            GAIN_KI:   gain = cfg.speed_int_gain;
            GAIN_KP:   gain = cfg.speed_prop_gain;
            default:   gain = cfg.pos_gain;
        endcase
    end

    assign mul_full = err_reg * $signed({1'b0, gain});

    // integrator and output sums
    assign integ_sum  = {integ_reg[DATA_W-1], integ_reg} + {scaled[DATA_W-1], scaled};
    assign integ_next = clamp_sym(integ_sum, cfg.integrator_limit);
    assign out_sum    = {scaled[DATA_W-1], scaled} + {integ_reg[DATA_W-1], integ_reg};

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            setp_reg   <= neg_sat(target_raw);
            pos_reg    <= neg_sat(cart_position_raw);
            cvel_reg   <= neg_sat(cart_velocity_raw);
            theta_reg  <= motor_angle;
            mspeed_reg <= motor_speed;
        end
        if (cmd.diff_en)
            err_reg <= sat_wide(diff_full);
        if (cmd.mul_en)
            prod_reg <= mul_full[PROD_W-1:0];
        if (cmd.clamp_en)
            ang_reg <= clamp_sym({scaled[DATA_W-1], scaled}, cfg.angle_limit);
        if (cmd.out_en)
            drive_reg <= sat_wide(out_sum);
    end

    // speed integrator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            integ_reg <= '0;
        else if (cmd.integ_en)
            integ_reg <= integ_next;
    end

    assign drive_voltage = drive_reg;

endmodule

`default_nettype wire

@@ rtl/flcpc_ctrl.sv @@
// Sequencer of the cascade controller: steps the datapath through the four
// loops and owns the request handshakes. Depends on flcpc_pkg.
`default_nettype none

module flcpc_ctrl
    import flcpc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output dp_cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF_POS,
        ST_MUL_POS,
        ST_DIFF_VEL,
        ST_MUL_VEL,
        ST_CLAMP_ANG,
        ST_DIFF_ANG,
        ST_MUL_ANG,
        ST_DIFF_SPD,
        ST_MUL_KI,
        ST_INTEG,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // command decode and next state
    always_comb
    begin
        cmd            = '0;
        cmd.diff_sel   = DIFF_POS;
        cmd.gain_sel   = GAIN_POS;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DIFF_POS;
            end
            ST_DIFF_POS:
            begin
                cmd.diff_en  = 1'b1;
                cmd.diff_sel = DIFF_POS;
                state_next   = ST_MUL_POS;
            end
            ST_MUL_POS:
            begin
                cmd.mul_en   = 1'b1;
                cmd.gain_sel = GAIN_POS;
                state_next   = ST_DIFF_VEL;
            end
            ST_DIFF_VEL:
            begin
                cmd.diff_en  = 1'b1;
                cmd.diff_sel = DIFF_VEL;
                state_next   = ST_MUL_VEL;
            end
            ST_MUL_VEL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.gain_sel = GAIN_CVEL;
                state_next   = ST_CLAMP_ANG;
            end
            ST_CLAMP_ANG:
            begin
                cmd.clamp_en = 1'b1;
                state_next   = ST_DIFF_ANG;
            end
            ST_DIFF_ANG:
            begin
                cmd.diff_en  = 1'b1;
                cmd.diff_sel = DIFF_ANG;
                state_next   = ST_MUL_ANG;
            end
            ST_MUL_ANG:
            begin
                cmd.mul_en   = 1'b1;
                cmd.gain_sel = GAIN_ANG;
                state_next   = ST_DIFF_SPD;
            end
            ST_DIFF_SPD:
            begin
                cmd.diff_en  = 1'b1;
                cmd.diff_sel = DIFF_SPD;
                state_next   = ST_MUL_KI;
            end
            ST_MUL_KI:
            begin
                cmd.mul_en   = 1'b1;
                cmd.gain_sel = GAIN_KI;
                state_next   = ST_INTEG;
            end
            ST_INTEG:
            begin
                // integrator update and proportional product share this cycle
                cmd.integ_en = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.gain_sel = GAIN_KP;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                // wait until the output register is free
                if (out_free)
                begin
                    cmd.out_en     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ rtl/four_loop_cascade_position_controller_unit.sv @@
// Four loop cascade position controller, top level: position P, velocity P
// with angle clamp, angle P and speed PI in signed fixed point, one request
// at a time. Each accepted request produces one drive_voltage result
// once the sequencer has stepped through all four loops; a new request
// is taken in the cycle after the result is written. The pace is set by
// the single shared 32 by 31 bit gain multiplier, used five times per
// request, each product followed by a subtract, clamp or sum step. A result
// waiting in the output register holds back only the final step.
// Configuration writes are always taken and act at once, so they belong
// between requests; indexes beyond the register list are ignored.
// Depends on flcpc_pkg, flcpc_cfg_regs, flcpc_ctrl and flcpc_datapath.
`default_nettype none

module four_loop_cascade_position_controller_unit
    import flcpc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [DATA_W-1:0] target_raw,
    input  wire logic signed [DATA_W-1:0] cart_position_raw,
    input  wire logic signed [DATA_W-1:0] cart_velocity_raw,
    input  wire logic signed [DATA_W-1:0] motor_angle,
    input  wire logic signed [DATA_W-1:0] motor_speed,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      drive_voltage,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [IDX_W-1:0]         cfg_index,
    input  wire logic [GAIN_W-1:0]        cfg_data
);

    cfg_t    cfg;
    dp_cmd_t cmd;
    logic    in_accept;

    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && in_ready;

    // configuration registers
    flcpc_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // sequencer
    flcpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // arithmetic
    flcpc_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .load              (in_accept),
        .cmd               (cmd),
        .cfg               (cfg),
        .target_raw        (target_raw),
        .cart_position_raw (cart_position_raw),
        .cart_velocity_raw (cart_velocity_raw),
        .motor_angle       (motor_angle),
        .motor_speed       (motor_speed),
        .drive_voltage     (drive_voltage)
    );

endmodule

`default_nettype wire

@@ tb/tb_four_loop_cascade_position_controller_unit.sv @@
// Self-checking testbench for the four loop cascade position controller.
// It sends control ticks and register writes, and predicts every drive voltage with its own
// fixed point model. Depends on flcpc_pkg and four_loop_cascade_position_controller_unit.

module tb_four_loop_cascade_position_controller_unit;
    import flcpc_pkg::*;

    localparam int     CLK_HALF     = 5;
    localparam int     RESET_CYCLES = 11;
    localparam int     DRAIN_CYCLES = 24;
    localparam int     CYCLE_LIMIT  = 600000;
    localparam int     MAX_REPORTS  = 10;
    localparam int     RAND_PHASES  = 8;
    localparam int     PHASE_ITEMS  = 150;
    localparam int     HOLD_CYCLES  = 400;
    localparam longint S32_HI       = 64'sd2147483647;
    localparam longint S32_LO       = -S32_HI - 1;

    // index past the end of the register map, writes to it are dropped
    localparam logic [IDX_W-1:0]         REG_OUTSIDE_MAP = IDX_W'(7);
    localparam logic [GAIN_W-1:0]        GAIN_MAX        = '1;
    localparam logic signed [DATA_W-1:0] WORD_MIN        = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] WORD_MAX        = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] FX_ONE          = 1 << FRAC_BITS;

    typedef struct packed {
        logic signed [DATA_W-1:0] target;
        logic signed [DATA_W-1:0] position;
        logic signed [DATA_W-1:0] cart_vel;
        logic signed [DATA_W-1:0] angle;
        logic signed [DATA_W-1:0] speed;
    } tick_sample_t;

    logic                     clk;
    logic                     rst_n             = 1'b0;
    logic                     in_valid          = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] target_raw        = '0;
    logic signed [DATA_W-1:0] cart_position_raw = '0;
    logic signed [DATA_W-1:0] cart_velocity_raw = '0;
    logic signed [DATA_W-1:0] motor_angle       = '0;
    logic signed [DATA_W-1:0] motor_speed       = '0;
    logic                     out_valid;
    logic                     out_ready         = 1'b0;
    logic signed [DATA_W-1:0] drive_voltage;
    logic                     cfg_valid         = 1'b0;
    logic                     cfg_ready;
    logic [IDX_W-1:0]         cfg_index         = '0;
    logic [GAIN_W-1:0]        cfg_data          = '0;

    // predictor state: register copy and speed integrator
    cfg_t   gains_model;
    longint integ_model;

    logic signed [DATA_W-1:0] pending_voltages[$];
    int  error_count        = 0;
    int  cycle_count        = 0;
    int  burst_left         = 0;
    int  hold_off_left      = 0;
    bit  sender_gaps_on     = 1'b0;
    bit  receiver_stalls_on = 1'b0;

    four_loop_cascade_position_controller_unit DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .target_raw        (target_raw),
        .cart_position_raw (cart_position_raw),
        .cart_velocity_raw (cart_velocity_raw),
        .motor_angle       (motor_angle),
        .motor_speed       (motor_speed),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .drive_voltage     (drive_voltage),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ---------------- fixed point predictor ----------------

    function automatic cfg_t default_gains();
        cfg_t c;
        c.pos_gain         = POS_GAIN_RST;
        c.cart_vel_gain    = CART_VEL_GAIN_RST;
        c.angle_gain       = ANGLE_GAIN_RST;
        c.speed_prop_gain  = SPEED_PROP_GAIN_RST;
        c.speed_int_gain   = SPEED_INT_GAIN_RST;
        c.angle_limit      = ANGLE_LIMIT_RST;
        c.integrator_limit = INTEGRATOR_LIMIT_RST;
        return c;
    endfunction

    function automatic longint sat_word(input longint v);
        if (v > S32_HI)
            return S32_HI;
        if (v < S32_LO)
            return S32_LO;
        return v;
    endfunction

    function automatic longint clamp_to_limit(input longint v, input logic [GAIN_W-1:0] lim);
        longint l;
        l = longint'({1'b0, lim});
        if (v > l)
            return l;
        if (v < -l)
            return -l;
        return v;
    endfunction

    // exact product, arithmetic shift floors towards minus infinity
    function automatic longint scale_by_gain(input longint a, input logic [GAIN_W-1:0] g);
        longint prod;
        prod = a * longint'({1'b0, g});
        return sat_word(prod >>> FRAC_BITS);
    endfunction

    // one control tick through the four loops, advances the integrator
    function automatic logic signed [DATA_W-1:0] predict_drive_voltage(input tick_sample_t s);
        longint setp, pos, cvel, vel_tgt, ang_tgt, spd_tgt, err, prop, u;
        setp    = sat_word(-longint'(s.target));
        pos     = sat_word(-longint'(s.position));
        cvel    = sat_word(-longint'(s.cart_vel));
        vel_tgt = scale_by_gain(sat_word(setp - pos), gains_model.pos_gain);
        ang_tgt = clamp_to_limit(scale_by_gain(sat_word(vel_tgt - cvel),
                                               gains_model.cart_vel_gain),
                                 gains_model.angle_limit);
        spd_tgt = scale_by_gain(sat_word(ang_tgt - longint'(s.angle)), gains_model.angle_gain);
        err     = sat_word(spd_tgt - longint'(s.speed));
        prop    = scale_by_gain(err, gains_model.speed_prop_gain);
        integ_model = clamp_to_limit(integ_model + scale_by_gain(err, gains_model.speed_int_gain),
                                     gains_model.integrator_limit);
        u = sat_word(prop + integ_model);
        return u[DATA_W-1:0];
    endfunction

    function automatic void apply_reg_model(input logic [IDX_W-1:0] idx,
                                            input logic [GAIN_W-1:0] value);
        case (idx)
            REG_POS_GAIN:         gains_model.pos_gain         = value;
            REG_CART_VEL_GAIN:    gains_model.cart_vel_gain    = value;
            REG_ANGLE_GAIN:       gains_model.angle_gain       = value;
            REG_SPEED_PROP_GAIN:  gains_model.speed_prop_gain  = value;
            REG_SPEED_INT_GAIN:   gains_model.speed_int_gain   = value;
            REG_ANGLE_LIMIT:      gains_model.angle_limit      = value;
            REG_INTEGRATOR_LIMIT: gains_model.integrator_limit = value;
            default: ;
        endcase
    endfunction

    // ---------------- random values ----------------

    function automatic logic signed [DATA_W-1:0] pick_word(input int spread);
        int v;
        case ($urandom_range(0, 9))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3, 4: return $urandom;
            default:
            begin
                v = int'($urandom_range(0, 2 * spread)) - spread;
                return v;
            end
        endcase
    endfunction

    function automatic tick_sample_t pick_tick(input int spread);
        tick_sample_t s;
        s.target   = pick_word(spread);
        s.position = pick_word(spread);
        s.cart_vel = pick_word(spread);
        s.angle    = pick_word(spread);
        s.speed    = pick_word(spread);
        return s;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain(input int top);
        case ($urandom_range(0, 15))
            0: return '0;
            1: return GAIN_MAX;
            default: return GAIN_W'($urandom_range(0, top));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_corner_gain();
        case ($urandom_range(0, 2))
            0: return '0;
            1: return GAIN_W'(1);
            default: return GAIN_MAX;
        endcase
    endfunction

    // style 0 reset values, 1 moderate, 2 full range, 3 corners
    function automatic cfg_t pick_settings(input int style);
        cfg_t c;
        case (style)
            0: c = default_gains();
            1:
            begin
                c.pos_gain         = pick_gain(1 << 20);
                c.cart_vel_gain    = pick_gain(1 << 19);
                c.angle_gain       = pick_gain(1 << 21);
                c.speed_prop_gain  = pick_gain(1 << 19);
                c.speed_int_gain   = pick_gain(1 << 22);
                c.angle_limit      = pick_gain(1 << 17);
                c.integrator_limit = pick_gain(1 << 19);
            end
            2:
            begin
                c.pos_gain         = GAIN_W'($urandom);
                c.cart_vel_gain    = GAIN_W'($urandom);
                c.angle_gain       = GAIN_W'($urandom);
                c.speed_prop_gain  = GAIN_W'($urandom);
                c.speed_int_gain   = GAIN_W'($urandom);
                c.angle_limit      = GAIN_W'($urandom);
                c.integrator_limit = GAIN_W'($urandom);
            end
            default:
            begin
                c.pos_gain         = pick_corner_gain();
                c.cart_vel_gain    = pick_corner_gain();
                c.angle_gain       = pick_corner_gain();
                c.speed_prop_gain  = pick_corner_gain();
                c.speed_int_gain   = pick_corner_gain();
                c.angle_limit      = pick_corner_gain();
                c.integrator_limit = pick_corner_gain();
            end
        endcase
        return c;
    endfunction

    // ---------------- channel drivers ----------------

    // send one tick request, then maybe pause the sender between bursts
    task automatic send_request(input tick_sample_t s);
        int gap;
        target_raw        <= s.target;
        cart_position_raw <= s.position;
        cart_velocity_raw <= s.cart_vel;
        motor_angle       <= s.angle;
        motor_speed       <= s.speed;
        in_valid          <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_voltages.push_back(predict_drive_voltage(s));
        if (sender_gaps_on)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(0, 12);
                gap        = $urandom_range(1, 14);
                in_valid  <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // leaves cfg_valid high so back to back writes run without a gap
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg_model(idx, value);
    endtask

    task automatic configure(input cfg_t c);
        write_reg(REG_POS_GAIN,         c.pos_gain);
        write_reg(REG_CART_VEL_GAIN,    c.cart_vel_gain);
        write_reg(REG_ANGLE_GAIN,       c.angle_gain);
        write_reg(REG_SPEED_PROP_GAIN,  c.speed_prop_gain);
        write_reg(REG_SPEED_INT_GAIN,   c.speed_int_gain);
        write_reg(REG_ANGLE_LIMIT,      c.angle_limit);
        write_reg(REG_INTEGRATOR_LIMIT, c.integrator_limit);
        cfg_valid <= 1'b0;
    endtask

    // block idle: nothing outstanding, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_voltages.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ---------------- tests ----------------

    // reset register values, field extremes and negation of the most negative input
    task automatic test_reset_defaults();
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        send_request('{'0, '0, '0, '0, '0});
        send_request('{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN});
        send_request('{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX});
        send_request('{WORD_MIN, '0, '0, '0, '0});
        send_request('{'0, WORD_MIN, '0, '0, '0});
        send_request('{'0, '0, WORD_MIN, '0, '0});
        send_request('{FX_ONE, FX_ONE >>> 1, -FX_ONE, FX_ONE >>> 3, -(FX_ONE >>> 2)});
        send_request('{WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX});
    endtask

    // every gain and limit at its top, then everything at zero
    task automatic test_gain_extremes();
        cfg_t c;
        wait_idle();
        c = {GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX};
        configure(c);
        send_request('{WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MIN});
        send_request('{WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX});
        send_request('{FX_ONE, -FX_ONE, 1, -1, FX_ONE});
        wait_idle();
        configure('0);
        send_request('{WORD_MIN, WORD_MAX, FX_ONE, -FX_ONE, WORD_MAX});
        send_request('{WORD_MAX, WORD_MIN, -FX_ONE, FX_ONE, WORD_MIN});
    endtask

    // zero angle limit forces the angle target to zero, zero integrator limit the integrator
    task automatic test_zero_limits();
        cfg_t c;
        wait_idle();
        c = default_gains();
        c.angle_limit = '0;
        configure(c);
        send_request('{-FX_ONE, FX_ONE, FX_ONE, '0, '0});
        send_request('{FX_ONE, -FX_ONE, '0, FX_ONE >>> 4, -FX_ONE});
        wait_idle();
        c.integrator_limit = '0;
        configure(c);
        send_request('{-FX_ONE, FX_ONE, FX_ONE, FX_ONE, FX_ONE});
        send_request('{WORD_MAX, WORD_MIN, '0, WORD_MIN, WORD_MAX});
    endtask

    // a write past the register map must change nothing
    task automatic test_register_outside_map();
        wait_idle();
        configure(default_gains());
        write_reg(REG_OUTSIDE_MAP, GAIN_W'($urandom));
        cfg_valid <= 1'b0;
        send_request('{FX_ONE, -FX_ONE, FX_ONE >>> 1, '0, FX_ONE});
        send_request('{-FX_ONE, FX_ONE, '0, FX_ONE >>> 2, '0});
    endtask

    // random ticks under a sequence of register settings and idling patterns
    task automatic test_random_settings();
        int spread;
        int style;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_idle();
            style = ph % 4;
            configure(pick_settings(style));
            case (style)
                0: spread = 1 << 17;
                1: spread = 1 << 18;
                2: spread = 1 << 24;
                default: spread = 1 << 16;
            endcase
            sender_gaps_on     = (ph == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            receiver_stalls_on = (ph == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(pick_tick(spread));
        end
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_output_hold_off();
        wait_idle();
        configure(pick_settings(1));
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b1;
        hold_off_left      = HOLD_CYCLES;
        for (int n = 0; n < 30; n++)
            send_request(pick_tick(1 << 18));
    endtask

    // ---------------- receiver and checker ----------------

    // out_ready follows a rotating random pattern, or a long hold-off when asked
    initial
    begin : receiver
        logic [15:0] stall_pattern;
        int          pattern_age;
        stall_pattern = '1;
        pattern_age   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_left > 0)
            begin
                out_ready <= 1'b0;
                hold_off_left--;
            end
            else if (!receiver_stalls_on)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= stall_pattern[pattern_age[3:0]];
                pattern_age++;
                if (pattern_age == 48)
                begin
                    pattern_age   = 0;
                    stall_pattern = 16'($urandom);
                end
            end
        end
    end

    // compare each accepted result with the oldest predicted voltage
    always @(posedge clk)
    begin : result_check
        logic signed [DATA_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_voltages.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("[%0d] drive_voltage %h arrived with no request pending",
                             cycle_count, drive_voltage);
            end
            else
            begin
                want = pending_voltages.pop_front();
                if (drive_voltage !== want)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("[%0d] drive_voltage mismatch: expected %h (%0d) got %h (%0d)",
                                 cycle_count, want, want, drive_voltage, drive_voltage);
                end
            end
        end
    end

    // watchdog on total run length
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------- test sequence ----------------

    initial
    begin : run
        gains_model = default_gains();
        integ_model = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_gain_extremes();
        test_zero_limits();
        test_register_outside_map();
        test_random_settings();
        test_output_hold_off();

        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
